@@ sv/assert_macros.svh @@
// Assertion macros shared by the estimator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while in reset.
`define NRLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Next-cycle implication, disabled while in reset.
`define NRLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define NRLE_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define NRLE_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/nrle_pkg.sv @@
// Shared types, constants and saturating arithmetic for the estimator.
package nrle_pkg;

	localparam int FRAC_BITS = 44;
	localparam int VALUE_WIDTH = 48;
	localparam int NOISE_FRAC = 28;
	localparam int LOG_FRAC = 40;
	localparam int LOG2_FRAC = 48;
	localparam int LN_SHIFT = LOG2_FRAC + 64 - LOG_FRAC;
	localparam int OUT_W = 48;
	localparam int DIV_NUM_W = 64 + FRAC_BITS;
	localparam int DIV_DEN_W = 24 + 16 + 44;

	localparam logic [63:0] VMAX_U = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;
	localparam logic [63:0] OMAX_U = (64'd1 << (OUT_W - 1)) - 64'd1;
	localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AC;
	// ceil(2^50 / 6): exact floor(n / 6) for n below 2^45
	localparam logic [63:0] RECIP6 = 64'd187649984473771;
	localparam int RECIP6_SHIFT = 50;

	localparam logic [2:0] REG_K = 3'd0;
	localparam logic [2:0] REG_GAIN = 3'd1;
	localparam logic [2:0] REG_DT = 3'd2;
	localparam logic [2:0] REG_D0 = 3'd3;
	localparam logic [2:0] REG_X0 = 3'd4;
	localparam logic [2:0] REG_WARM = 3'd5;
	localparam logic [2:0] REG_MEAS = 3'd6;
	localparam logic [2:0] REG_RS = 3'd7;

	localparam logic [1:0] PH_WARM = 2'd0;
	localparam logic [1:0] PH_MEAS = 2'd1;
	localparam logic [1:0] PH_DONE = 2'd2;

	typedef logic signed [VALUE_WIDTH-1:0] value_t;

	typedef struct packed {
		logic signed [31:0] noise_sample;
		logic               restart;
	} item_t;

	typedef struct packed {
		logic [1:0]         phase;
		logic signed [47:0] base_position;
		logic               renormalized;
		logic signed [47:0] log_growth;
		logic [23:0]        renorm_total;
		logic signed [47:0] growth_rate;
		logic               rate_valid;
		logic               run_done;
	} result_t;

	function automatic value_t sat_v(input logic signed [VALUE_WIDTH:0] s);
		value_t r;
		if (s[VALUE_WIDTH] != s[VALUE_WIDTH-1]) begin
			r = s[VALUE_WIDTH] ? value_t'(~VMAX_U) : value_t'(VMAX_U);
		end else begin
			r = s[VALUE_WIDTH-1:0];
		end
		return r;
	endfunction

	function automatic value_t vadd(input value_t a, input value_t b);
		logic signed [VALUE_WIDTH:0] s;
		s = {a[VALUE_WIDTH-1], a} + {b[VALUE_WIDTH-1], b};
		return sat_v(s);
	endfunction

	function automatic value_t vsub(input value_t a, input value_t b);
		logic signed [VALUE_WIDTH:0] s;
		s = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
		return sat_v(s);
	endfunction

	// zero-extend so the most negative value gives its true magnitude
	function automatic logic [63:0] mag_v(input value_t a);
		logic [63:0] r;
		r = {{(64 - VALUE_WIDTH){1'b0}}, (a[VALUE_WIDTH-1] ? -a : a)};
		return r;
	endfunction

	// Round to nearest (ties up on magnitude), then apply sign and saturate.
	function automatic logic [63:0] mul_fin(input logic neg, input logic [127:0] p,
			input logic [6:0] sh, input logic [63:0] maxu);
		logic [127:0] r;
		logic [63:0] v;
		r = (p + (128'd1 << (sh - 7'd1))) >> sh;
		if (r > {64'd0, maxu}) begin
			v = neg ? ~maxu : maxu;
		end else begin
			v = neg ? -r[63:0] : r[63:0];
		end
		return v;
	endfunction

	function automatic logic signed [63:0] add64_sat(input logic signed [63:0] a,
			input logic signed [63:0] b);
		logic signed [64:0] s;
		logic signed [63:0] r;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63]) begin
			r = s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
		end else begin
			r = s[63:0];
		end
		return r;
	endfunction

endpackage

@@ sv/nrle_mul.sv @@
// Shared 64x64 unsigned multiplier built from four 32x32 partial products.
module nrle_mul (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [63:0]  a,
	input  logic [63:0]  b,
	output logic         done,
	output logic [127:0] prod
);
	logic [63:0]  a_q, b_q;
	logic [2:0]   cnt_q;
	logic         busy_q, done_q, pv_s1;
	logic [63:0]  pp_s1;
	logic [1:0]   sel_s1;
	logic [127:0] acc_q;
	logic [31:0]  ah, bh;
	logic [127:0] pp_ext;

	assign ah = cnt_q[1] ? a_q[63:32] : a_q[31:0];
	assign bh = cnt_q[0] ? b_q[63:32] : b_q[31:0];

	always_comb begin
		case (sel_s1)
			2'd0:    pp_ext = {64'd0, pp_s1};
			2'd3:    pp_ext = {pp_s1, 64'd0};
			default: pp_ext = {32'd0, pp_s1, 32'd0};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			pv_s1 <= 1'b0;
			cnt_q <= 3'd0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				a_q <= a;
				b_q <= b;
				acc_q <= '0;
				cnt_q <= 3'd0;
				busy_q <= 1'b1;
				pv_s1 <= 1'b0;
			end else if (busy_q) begin
				if (cnt_q != 3'd4) begin
					pp_s1 <= ah * bh;
					sel_s1 <= cnt_q[1:0];
					pv_s1 <= 1'b1;
				end else begin
					pv_s1 <= 1'b0;
				end
				if (pv_s1) acc_q <= acc_q + pp_ext;
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd4) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign prod = acc_q;
endmodule

@@ sv/nrle_div.sv @@
// Restoring radix-2 divider, one quotient bit per cycle, with round-up flag.
module nrle_div
	import nrle_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic                 done,
	output logic [DIV_NUM_W-1:0] quo,
	output logic                 round_up
);
	localparam int CW = $clog2(DIV_NUM_W);

	logic [DIV_NUM_W-1:0] num_q, quo_q;
	logic [DIV_DEN_W-1:0] den_q, rem_q;
	logic [CW-1:0]        cnt_q;
	logic                 busy_q, done_q;
	logic [DIV_DEN_W:0]   r2, diff;
	logic                 ge;

	assign r2 = {rem_q, num_q[DIV_NUM_W-1]};
	assign ge = r2 >= {1'b0, den_q};
	assign diff = r2 - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				num_q <= num;
				den_q <= den;
				rem_q <= '0;
				quo_q <= '0;
				cnt_q <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? diff[DIV_DEN_W-1:0] : r2[DIV_DEN_W-1:0];
				quo_q <= {quo_q[DIV_NUM_W-2:0], ge};
				num_q <= {num_q[DIV_NUM_W-2:0], 1'b0};
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(DIV_NUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign done = done_q;
	assign quo = quo_q;
	assign round_up = {rem_q, 1'b0} >= {1'b0, den_q};
endmodule

@@ sv/noisy_rk4_lyapunov_estimator.sv @@
// Every multiply goes through one shared multiplier; a warmup step takes 14 multiplies,
// a measuring step 26 (two RK4 evaluations back to back).
// A renormalizing step adds a log2 normalize and squaring.
// The final step adds two multiplies and a divide. One request at a time.
// Reset clears control state and loads register defaults; base position starts at zero.
`include "assert_macros.svh"
module noisy_rk4_lyapunov_estimator (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  nrle_pkg::item_t  item,
	output logic             result_valid,
	input  logic             result_ready,
	output nrle_pkg::result_t result,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [47:0]      cfg_data
);
	import nrle_pkg::*;

	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_NOISE = 5'd1;
	localparam logic [4:0] S_DT6 = 5'd2;
	localparam logic [4:0] S_SQ = 5'd3;
	localparam logic [4:0] S_CUBE = 5'd4;
	localparam logic [4:0] S_STEP = 5'd5;
	localparam logic [4:0] S_INC = 5'd6;
	localparam logic [4:0] S_RENORM = 5'd7;
	localparam logic [4:0] S_NORM = 5'd8;
	localparam logic [4:0] S_LOGSQ = 5'd9;
	localparam logic [4:0] S_LN = 5'd10;
	localparam logic [4:0] S_FIN = 5'd11;
	localparam logic [4:0] S_DEN1 = 5'd12;
	localparam logic [4:0] S_DEN2 = 5'd13;
	localparam logic [4:0] S_DIV = 5'd14;
	localparam logic [4:0] S_EMIT = 5'd15;

	// configuration registers
	logic signed [47:0] k_q, x0_q;
	logic [46:0] gain_q;
	logic [43:0] dt_q, d0_q;
	logic [23:0] warm_q, meas_q;
	logic [15:0] rs_q;
	logic [43:0] dt_e, d0_e;
	logic [15:0] rs_e;

	// run state
	logic [4:0]  state_q;
	value_t      bp_q, pp_q;
	logic [24:0] step_q;
	logic [15:0] rpc_q;
	logic signed [63:0] acc_q;
	logic [23:0] rcnt_q;
	logic [1:0]  phase_q, phase_out_q;

	// per-step working registers
	logic signed [31:0] sample_q;
	value_t      noise_q, x_q, y_q, s_q, dr_q, t_q;
	logic [43:0] dt6_q;
	logic [1:0]  j_q;
	logic        traj_q, up_q, which_q, issued_q;
	logic [63:0] n_q, m_q;
	logic [5:0]  e_q, i_q;
	logic [47:0] frac_q;
	logic [53:0] l1_q;
	logic signed [54:0] d_q;
	logic signed [47:0] lg_q, rate_q;
	logic        renormed_q, valid_q, done_q;
	logic [39:0] cr_q;
	logic [83:0] den_q;
	result_t     out_q;
	logic        out_valid_q;

	// accept-time updates
	value_t      a_bp, a_pp;
	logic [24:0] a_step;
	logic [15:0] a_rpc;
	logic signed [63:0] a_acc;
	logic [23:0] a_rcnt;
	logic [1:0]  a_phase;

	// shared units
	logic         mul_start, mul_done, div_start, div_done, div_round;
	logic [63:0]  mul_a, mul_b;
	logic [127:0] mul_p;
	logic [DIV_NUM_W-1:0] div_quo;
	logic         fin_neg;
	logic [6:0]   fin_sh;
	logic [63:0]  fin_max, fin_raw;
	value_t       fin_v, dr_n, s_n, d0_v, newpos;
	logic [63:0]  mm, sep;
	logic         up_n;
	logic [47:0]  frac_n;
	logic [53:0]  l_n;
	logic [15:0]  rpc_inc;
	logic [DIV_NUM_W:0] q_tot;
	logic signed [47:0] rate_n;
	logic [63:0]  acc_mag;
	logic         accept;

	assign dt_e = (dt_q == 44'd0) ? 44'd1 : dt_q;
	assign d0_e = (d0_q == 44'd0) ? 44'd1 : d0_q;
	assign rs_e = (rs_q == 16'd0) ? 16'd1 : rs_q;
	assign d0_v = value_t'({1'b0, d0_e});

	assign item_ready = (state_q == S_IDLE);
	assign accept = item_valid && item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_q <= '0;
			gain_q <= 47'd17592186;
			dt_q <= 44'd175921860444;
			d0_q <= 44'd175922;
			x0_q <= '0;
			warm_q <= 24'd50000;
			meas_q <= 24'd200000;
			rs_q <= 16'd100;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_K:    k_q <= cfg_data;
				REG_GAIN: gain_q <= cfg_data[46:0];
				REG_DT:   dt_q <= cfg_data[43:0];
				REG_D0:   d0_q <= cfg_data[43:0];
				REG_X0:   x0_q <= cfg_data;
				REG_WARM: warm_q <= cfg_data[23:0];
				REG_MEAS: meas_q <= cfg_data[23:0];
				REG_RS:   rs_q <= cfg_data[15:0];
				default:  ;
			endcase
		end
	end

	// restart and phase changes taken at the start of a step
	always_comb begin
		a_bp = bp_q;
		a_pp = pp_q;
		a_step = step_q;
		a_rpc = rpc_q;
		a_acc = acc_q;
		a_rcnt = rcnt_q;
		a_phase = phase_q;
		if (item.restart) begin
			a_bp = value_t'(x0_q);
			a_pp = '0;
			a_step = '0;
			a_rpc = '0;
			a_acc = '0;
			a_rcnt = '0;
			a_phase = PH_WARM;
		end
		if (a_phase == PH_WARM && a_step >= {1'b0, warm_q}) begin
			a_pp = vadd(a_bp, d0_v);
			a_step = '0;
			a_rpc = '0;
			a_phase = PH_MEAS;
		end
		if (a_phase == PH_MEAS && a_step >= {1'b0, meas_q}) a_phase = PH_DONE;
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		fin_neg = 1'b0;
		fin_sh = 7'(FRAC_BITS);
		fin_max = VMAX_U;
		case (state_q)
			S_NOISE: begin
				mul_a = 64'(gain_q);
				mul_b = {32'd0, (sample_q[31] ? -sample_q : sample_q)};
				fin_neg = sample_q[31];
				fin_sh = 7'(NOISE_FRAC);
			end
			S_DT6: begin
				mul_a = 64'(dt_e) + 64'd3;
				mul_b = RECIP6;
			end
			S_SQ: begin
				mul_a = mag_v(y_q);
				mul_b = mag_v(y_q);
			end
			S_CUBE: begin
				mul_a = mag_v(t_q);
				mul_b = mag_v(y_q);
				fin_neg = y_q[VALUE_WIDTH-1];
			end
			S_STEP: begin
				mul_a = 64'(dt_e);
				mul_b = mag_v(dr_q);
				fin_neg = dr_q[VALUE_WIDTH-1];
				fin_sh = (j_q == 2'd2) ? 7'(FRAC_BITS) : 7'(FRAC_BITS + 1);
			end
			S_INC: begin
				mul_a = 64'(dt6_q);
				mul_b = mag_v(s_q);
				fin_neg = s_q[VALUE_WIDTH-1];
			end
			S_LOGSQ: begin
				mul_a = m_q;
				mul_b = m_q;
			end
			S_LN: begin
				mul_a = 64'(d_q[54] ? -d_q : d_q);
				mul_b = LN2_Q64;
				fin_neg = d_q[54];
				fin_sh = 7'(LN_SHIFT);
				fin_max = OMAX_U;
			end
			S_DEN1: begin
				mul_a = 64'(rcnt_q);
				mul_b = 64'(rs_e);
			end
			S_DEN2: begin
				mul_a = 64'(cr_q);
				mul_b = 64'(dt_e);
			end
			default: ;
		endcase
	end

	assign mul_start = !issued_q && (state_q == S_NOISE || state_q == S_DT6 ||
		state_q == S_SQ || state_q == S_CUBE || state_q == S_STEP || state_q == S_INC ||
		state_q == S_LOGSQ || state_q == S_LN || state_q == S_DEN1 || state_q == S_DEN2);
	assign div_start = !issued_q && (state_q == S_DIV);

	assign fin_raw = mul_fin(fin_neg, mul_p, fin_sh, fin_max);
	assign fin_v = fin_raw[VALUE_WIDTH-1:0];
	assign dr_n = vsub(vadd(value_t'(k_q), t_q), fin_v);

	always_comb begin
		case (j_q)
			2'd0:    s_n = dr_n;
			2'd3:    s_n = vadd(s_q, dr_n);
			default: s_n = vadd(s_q, vadd(dr_n, dr_n));
		endcase
	end

	assign newpos = vadd(x_q, vadd(fin_v, noise_q));
	assign up_n = pp_q > bp_q;
	// separation can reach 2^48 - 1: form it at full width
	assign sep = up_n ? 64'(pp_q) - 64'(bp_q) : 64'(bp_q) - 64'(pp_q);
	assign rpc_inc = rpc_q + 16'd1;
	assign mm = mul_p[125:62];
	assign frac_n = {frac_q[46:0], mm[63]};
	assign l_n = {e_q, frac_n};
	assign acc_mag = acc_q[63] ? -acc_q : acc_q;
	assign q_tot = {1'b0, div_quo} + (DIV_NUM_W + 1)'(div_round);

	always_comb begin
		if (q_tot > (DIV_NUM_W + 1)'(OMAX_U)) begin
			rate_n = acc_q[63] ? 48'(~OMAX_U) : 48'(OMAX_U);
		end else begin
			rate_n = acc_q[63] ? -q_tot[47:0] : q_tot[47:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			issued_q <= 1'b0;
			out_valid_q <= 1'b0;
			bp_q <= '0;
			pp_q <= '0;
			step_q <= '0;
			rpc_q <= '0;
			acc_q <= '0;
			rcnt_q <= '0;
			phase_q <= PH_WARM;
		end else begin
			if (out_valid_q && result_ready) out_valid_q <= 1'b0;
			if (mul_start || div_start) issued_q <= 1'b1;
			if (mul_done || div_done) issued_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						bp_q <= a_bp;
						pp_q <= a_pp;
						step_q <= a_step;
						rpc_q <= a_rpc;
						acc_q <= a_acc;
						rcnt_q <= a_rcnt;
						phase_q <= a_phase;
						phase_out_q <= a_phase;
						sample_q <= item.noise_sample;
						renormed_q <= 1'b0;
						lg_q <= '0;
						rate_q <= '0;
						valid_q <= 1'b0;
						done_q <= 1'b0;
						state_q <= (a_phase == PH_DONE) ? S_EMIT : S_NOISE;
					end
				end
				S_NOISE: if (mul_done) begin
					noise_q <= fin_v;
					state_q <= S_DT6;
				end
				S_DT6: if (mul_done) begin
					dt6_q <= mul_p[RECIP6_SHIFT+43:RECIP6_SHIFT];
					x_q <= bp_q;
					y_q <= bp_q;
					j_q <= 2'd0;
					traj_q <= 1'b0;
					state_q <= S_SQ;
				end
				S_SQ: if (mul_done) begin
					t_q <= fin_v;
					state_q <= S_CUBE;
				end
				S_CUBE: if (mul_done) begin
					dr_q <= dr_n;
					s_q <= s_n;
					state_q <= (j_q == 2'd3) ? S_INC : S_STEP;
				end
				S_STEP: if (mul_done) begin
					y_q <= vadd(x_q, fin_v);
					j_q <= j_q + 2'd1;
					state_q <= S_SQ;
				end
				S_INC: if (mul_done) begin
					if (!traj_q) bp_q <= newpos;
					else pp_q <= newpos;
					if (phase_q == PH_WARM) begin
						step_q <= step_q + 25'd1;
						state_q <= S_EMIT;
					end else if (!traj_q) begin
						// run the perturbed trajectory on the same noise
						traj_q <= 1'b1;
						x_q <= pp_q;
						y_q <= pp_q;
						j_q <= 2'd0;
						state_q <= S_SQ;
					end else begin
						state_q <= S_RENORM;
					end
				end
				S_RENORM: begin
					step_q <= step_q + 25'd1;
					state_q <= S_FIN;
					if (rpc_inc >= rs_e) begin
						rpc_q <= '0;
						if (sep != 64'd0) begin
							up_q <= up_n;
							n_q <= sep;
							e_q <= 6'd63;
							which_q <= 1'b0;
							state_q <= S_NORM;
						end
					end else begin
						rpc_q <= rpc_inc;
					end
				end
				S_NORM: begin
					// shift to the leading one, one bit a cycle
					if (!n_q[63] && e_q != 6'd0) begin
						n_q <= {n_q[62:0], 1'b0};
						e_q <= e_q - 6'd1;
					end else begin
						m_q <= {1'b0, n_q[63:1]};
						frac_q <= '0;
						i_q <= '0;
						state_q <= S_LOGSQ;
					end
				end
				S_LOGSQ: if (mul_done) begin
					frac_q <= frac_n;
					m_q <= mm[63] ? {1'b0, mm[63:1]} : mm;
					i_q <= i_q + 6'd1;
					if (i_q == 6'(LOG2_FRAC - 1)) begin
						if (!which_q) begin
							l1_q <= l_n;
							n_q <= 64'(d0_e);
							e_q <= 6'd63;
							which_q <= 1'b1;
							state_q <= S_NORM;
						end else begin
							d_q <= $signed({1'b0, l1_q}) - $signed({1'b0, l_n});
							state_q <= S_LN;
						end
					end
				end
				S_LN: if (mul_done) begin
					lg_q <= fin_raw[47:0];
					acc_q <= add64_sat(acc_q, 64'(signed'(fin_raw[47:0])));
					if (rcnt_q != 24'hFFFFFF) rcnt_q <= rcnt_q + 24'd1;
					renormed_q <= 1'b1;
					pp_q <= up_q ? vadd(bp_q, d0_v) : vsub(bp_q, d0_v);
					state_q <= S_FIN;
				end
				S_FIN: begin
					state_q <= S_EMIT;
					if (step_q >= {1'b0, meas_q}) begin
						done_q <= 1'b1;
						phase_q <= PH_DONE;
						if (rcnt_q != 24'd0) begin
							valid_q <= 1'b1;
							state_q <= S_DEN1;
						end
					end
				end
				S_DEN1: if (mul_done) begin
					cr_q <= mul_p[39:0];
					state_q <= S_DEN2;
				end
				S_DEN2: if (mul_done) begin
					den_q <= mul_p[83:0];
					state_q <= S_DIV;
				end
				S_DIV: if (div_done) begin
					rate_q <= rate_n;
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					// hold until the output register is free
					if (!out_valid_q || result_ready) begin
						out_q.phase <= phase_out_q;
						out_q.base_position <= 48'(bp_q);
						out_q.renormalized <= renormed_q;
						out_q.log_growth <= lg_q;
						out_q.renorm_total <= rcnt_q;
						out_q.growth_rate <= rate_q;
						out_q.rate_valid <= valid_q;
						out_q.run_done <= done_q;
						out_valid_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	nrle_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.prod   (mul_p)
	);

	nrle_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.num      ({acc_mag, FRAC_BITS'(0)}),
		.den      (den_q),
		.done     (div_done),
		.quo      (div_quo),
		.round_up (div_round)
	);

	assign result_valid = out_valid_q;
	assign result = out_q;

	`NRLE_ASSERT_IMP(a_idle_no_unit, clk, arst_n, state_q == S_IDLE, !issued_q)
	`NRLE_ASSERT_IMP(a_done_was_issued, clk, arst_n, mul_done || div_done, issued_q)
	`NRLE_ASSERT_IMP(a_rate_on_final, clk, arst_n, result_valid && result.rate_valid, result.run_done)
	`NRLE_ASSERT_IMP(a_renorm_measuring, clk, arst_n, result_valid && result.renormalized,
		result.phase == PH_MEAS)
endmodule
